>>> rtl/core/bpq_pkg.sv
// Shared constants, codes and types of the bucket priority queue.
// Used by the channel interfaces, the occupancy chain and the top level.
package bpq_pkg;

    localparam int NUM_KEYS    = 256;
    localparam int KEY_W       = 8;
    localparam int CAPACITY    = 1024;
    localparam int SLOT_W      = 10;
    localparam int COUNT_W     = 11;
    localparam int ENTRY_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int KIND_W      = 2;

    // occupancy chain: each cell owns a slice of the buckets
    localparam int CELL_KEYS   = 32;
    localparam int CELL_IDX_W  = 5;
    localparam int NUM_CELLS   = NUM_KEYS / CELL_KEYS;
    localparam int CELL_BASE_W = KEY_W - CELL_IDX_W;
    localparam int SETTLE_W    = $clog2(NUM_CELLS + 1);

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BAD_KEY = 2'd3;

    // lowest occupied bucket seen so far along the chain
    typedef struct packed {
        logic             found;
        logic [KEY_W-1:0] key;
    } t_find;

    // occupancy update broadcast to all cells
    typedef struct packed {
        logic             set;
        logic             clr;
        logic             clr_all;
        logic [KEY_W-1:0] key;
    } t_occ_cmd;

    typedef struct packed {
        logic [ENTRY_W-1:0]  removed_entry;
        logic [KEY_W-1:0]    removed_key;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
    } t_result;

endpackage

>>> rtl/core/bpq_if.sv
// Valid/ready channel interfaces for the request and result words.
// Depends on bpq_pkg for field widths.
interface bpq_in_if;
    logic                         valid;
    logic                         ready;
    logic [bpq_pkg::KIND_W-1:0]   kind;
    logic [bpq_pkg::KEY_W-1:0]    key;
    logic [bpq_pkg::ENTRY_W-1:0]  entry;

    modport source (output valid, output kind, output key, output entry, input ready);
    modport sink   (input valid, input kind, input key, input entry, output ready);
endinterface

interface bpq_out_if;
    logic                          valid;
    logic                          ready;
    logic [bpq_pkg::ENTRY_W-1:0]   removed_entry;
    logic [bpq_pkg::KEY_W-1:0]     removed_key;
    logic [bpq_pkg::STATUS_W-1:0]  status;
    logic [bpq_pkg::COUNT_W-1:0]   count;
    logic                          is_empty;

    modport source (output valid, output removed_entry, output removed_key,
                    output status, output count, output is_empty, input ready);
    modport sink   (input valid, input removed_entry, input removed_key,
                    input status, input count, input is_empty, output ready);
endinterface

>>> rtl/core/bpq_cell.sv
// One occupancy cell: holds the occupied bits of a slice of buckets and
// forwards the lowest occupied bucket found so far to its neighbor. Uses bpq_pkg.
module bpq_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [bpq_pkg::CELL_BASE_W-1:0]    i_base,
    input  bpq_pkg::t_occ_cmd                  i_cmd,
    input  bpq_pkg::t_find                     i_prev,
    output bpq_pkg::t_find                     o_next,
    output logic [bpq_pkg::CELL_KEYS-1:0]      o_occ
);

    logic [bpq_pkg::CELL_KEYS-1:0]  r_occ;
    bpq_pkg::t_find                 r_next;
    logic                           w_hit;
    logic                           w_any;
    logic [bpq_pkg::CELL_IDX_W-1:0] w_idx;
    logic [bpq_pkg::CELL_IDX_W-1:0] w_cmd_idx;

    assign w_hit     = (i_cmd.key[bpq_pkg::KEY_W-1:bpq_pkg::CELL_IDX_W] == i_base);
    assign w_cmd_idx = i_cmd.key[bpq_pkg::CELL_IDX_W-1:0];

    // lowest set bit of the slice
    always_comb begin
        w_any = 1'b0;
        w_idx = '0;
        for (int b = bpq_pkg::CELL_KEYS - 1; b >= 0; b--) begin
            if (r_occ[b]) begin
                w_any = 1'b1;
                w_idx = bpq_pkg::CELL_IDX_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_next <= '0;
        end else begin
            if (i_cmd.clr_all) begin
                r_occ <= '0;
            end else begin
                if (i_cmd.set && w_hit) begin
                    r_occ[w_cmd_idx] <= 1'b1;
                end
                if (i_cmd.clr && w_hit) begin
                    r_occ[w_cmd_idx] <= 1'b0;
                end
            end
            // lower cells win; otherwise offer our own lowest bucket
            if (i_prev.found) begin
                r_next <= i_prev;
            end else begin
                r_next.found <= w_any;
                r_next.key   <= {i_base, w_idx};
            end
        end
    end

    assign o_next = r_next;
    assign o_occ  = r_occ;

endmodule

>>> rtl/core/bpq_chain.sv
// Row of occupancy cells with a settle counter; gives the lowest occupied
// bucket once the chain has caught up with the last update. Uses bpq_cell, bpq_pkg.
module bpq_chain (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bpq_pkg::t_occ_cmd           i_cmd,
    input  logic [bpq_pkg::KEY_W-1:0]   i_key,
    output logic                        o_occ_hit,
    output bpq_pkg::t_find              o_min,
    output logic                        o_settled
);

    bpq_pkg::t_find                  w_link [bpq_pkg::NUM_CELLS];
    logic [bpq_pkg::NUM_KEYS-1:0]    w_occ;
    logic [bpq_pkg::SETTLE_W-1:0]    r_settle;

    for (genvar g = 0; g < bpq_pkg::NUM_CELLS; g++) begin : g_cell
        bpq_pkg::t_find w_prev;
        if (g == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_rest
            assign w_prev = w_link[g-1];
        end
        bpq_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_base  (bpq_pkg::CELL_BASE_W'(g)),
            .i_cmd   (i_cmd),
            .i_prev  (w_prev),
            .o_next  (w_link[g]),
            .o_occ   (w_occ[g*bpq_pkg::CELL_KEYS +: bpq_pkg::CELL_KEYS])
        );
    end

    // each cell registers its link; the counter waits for a change to reach the end of the row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle <= '0;
        end else if (i_cmd.set || i_cmd.clr || i_cmd.clr_all) begin
            r_settle <= bpq_pkg::SETTLE_W'(bpq_pkg::NUM_CELLS);
        end else if (r_settle != '0) begin
            r_settle <= r_settle - 1'b1;
        end
    end

    assign o_occ_hit = w_occ[i_key];
    assign o_min     = w_link[bpq_pkg::NUM_CELLS-1];
    assign o_settled = (r_settle == '0);

endmodule

>>> rtl/core/bucket_priority_queue_fifo_unit.sv
// Bucket priority queue, FIFO order within a key: top level.
// Uses bpq_pkg, bpq_in_if/bpq_out_if and bpq_chain.
//
// Usage: i_in carries request words (kind, key, entry); o_out returns one
// result word per request (removed_entry, removed_key, status, count,
// is_empty), in request order. Words move on valid && ready.
// One request is in work at a time. Steps from acceptance to the result register:
//   insert            tail and free-link read, then list writes
//   remove            wait for the 8-cell occupancy chain to settle after a
//                     bucket filled or emptied, then list reads, then list writes
//   clear, rejected insert, empty remove, unknown kind: answered on acceptance
// The linked-list memories (one read and one write per cycle each) set the
// insert and remove steps; the cell count sets the settle wait.
// A result waiting on a stalled receiver moves to a one-word hold register,
// so the next request can still be accepted; ready drops only while that
// hold register is full or a request is in work.
// Reset empties the queue at once: bucket occupancy lives in flip-flops,
// the list memories need no clearing pass.
module bucket_priority_queue_fifo_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpq_in_if.sink     i_in,
    bpq_out_if.source  o_out
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_RHEAD = 3'd3;
    localparam logic [2:0] S_RWR   = 3'd4;

    localparam int SW = bpq_pkg::SLOT_W;
    localparam int KW = bpq_pkg::KEY_W;
    localparam int EW = bpq_pkg::ENTRY_W;
    localparam int CW = bpq_pkg::COUNT_W;

    // list memories
    logic [EW-1:0] r_entry_mem [bpq_pkg::CAPACITY];
    logic [SW-1:0] r_link_mem  [bpq_pkg::CAPACITY];
    logic [SW-1:0] r_head_mem  [bpq_pkg::NUM_KEYS];
    logic [SW-1:0] r_tail_mem  [bpq_pkg::NUM_KEYS];

    logic [2:0]      r_state, n_state;
    logic [SW-1:0]   r_free_head;
    logic            r_free_nonempty;
    logic [CW-1:0]   r_fresh;
    logic [CW-1:0]   r_count;
    logic [KW-1:0]   r_key;
    logic [EW-1:0]   r_entry;
    logic            r_occ_hit;
    logic [KW-1:0]   r_rkey;

    // registered read data
    logic [EW-1:0]   r_ent_rd;
    logic [SW-1:0]   r_link_rd;
    logic [SW-1:0]   r_head_rd;
    logic [SW-1:0]   r_tail_rd;

    // result register and hold register
    logic              r_out_valid;
    bpq_pkg::t_result  r_out;
    logic              r_pend;
    bpq_pkg::t_result  r_res;

    logic              w_ready, w_accept, w_finish, w_out_free;
    logic              w_key_bad, w_full, w_empty;
    logic [SW-1:0]     w_slot;
    bpq_pkg::t_result  w_result;
    bpq_pkg::t_occ_cmd w_cmd;
    logic              w_occ_hit, w_settled;
    bpq_pkg::t_find    w_min;

    logic            w_ent_re, w_link_re, w_head_re, w_tail_re;
    logic [SW-1:0]   w_ent_ra, w_link_ra;
    logic [KW-1:0]   w_head_ra, w_tail_ra;
    logic            w_ent_we, w_link_we, w_head_we, w_tail_we;
    logic [SW-1:0]   w_ent_wa, w_link_wa, w_link_wd, w_head_wd, w_tail_wd;
    logic [KW-1:0]   w_head_wa, w_tail_wa;

    assign w_ready    = (r_state == S_IDLE) && !r_pend;
    assign w_accept   = i_in.valid && w_ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    assign w_key_bad = ({1'b0, i_in.key} >= (KW+1)'(bpq_pkg::NUM_KEYS));
    assign w_full    = (r_count >= CW'(bpq_pkg::CAPACITY));
    assign w_empty   = (r_count == '0);
    assign w_slot    = r_free_nonempty ? r_free_head : r_fresh[SW-1:0];

    bpq_chain u_chain (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_key     (i_in.key),
        .o_occ_hit (w_occ_hit),
        .o_min     (w_min),
        .o_settled (w_settled)
    );

    always_comb begin
        n_state   = r_state;
        w_finish  = 1'b0;
        w_result  = '0;
        w_cmd     = '0;
        w_ent_re  = 1'b0;
        w_ent_ra  = r_head_rd;
        w_link_re = 1'b0;
        w_link_ra = r_free_head;
        w_head_re = 1'b0;
        w_head_ra = w_min.key;
        w_tail_re = 1'b0;
        w_tail_ra = i_in.key;
        w_ent_we  = 1'b0;
        w_ent_wa  = w_slot;
        w_link_we = 1'b0;
        w_link_wa = r_tail_rd;
        w_link_wd = w_slot;
        w_head_we = 1'b0;
        w_head_wa = r_key;
        w_head_wd = w_slot;
        w_tail_we = 1'b0;
        w_tail_wa = r_key;
        w_tail_wd = w_slot;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_in.kind)
                        bpq_pkg::KIND_INSERT: begin
                            if (w_key_bad || w_full) begin
                                w_finish        = 1'b1;
                                w_result.status = w_key_bad ? bpq_pkg::STATUS_BAD_KEY
                                                            : bpq_pkg::STATUS_FULL;
                                w_result.count    = r_count;
                                w_result.is_empty = w_empty;
                            end else begin
                                // fetch tail of the bucket and next free slot
                                w_tail_re = 1'b1;
                                w_link_re = 1'b1;
                                n_state   = S_INS;
                            end
                        end
                        bpq_pkg::KIND_REMOVE: begin
                            if (w_empty) begin
                                w_finish          = 1'b1;
                                w_result.status   = bpq_pkg::STATUS_EMPTY;
                                w_result.count    = r_count;
                                w_result.is_empty = 1'b1;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        bpq_pkg::KIND_CLEAR: begin
                            w_finish          = 1'b1;
                            w_cmd.clr_all     = 1'b1;
                            w_result.status   = bpq_pkg::STATUS_OK;
                            w_result.count    = '0;
                            w_result.is_empty = 1'b1;
                        end
                        default: begin
                            w_finish          = 1'b1;
                            w_result.status   = bpq_pkg::STATUS_OK;
                            w_result.count    = r_count;
                            w_result.is_empty = w_empty;
                        end
                    endcase
                end
            end
            S_INS: begin
                w_ent_we  = 1'b1;
                w_tail_we = 1'b1;
                if (r_occ_hit) begin
                    w_link_we = 1'b1;
                end else begin
                    w_head_we = 1'b1;
                    w_cmd.set = 1'b1;
                    w_cmd.key = r_key;
                end
                w_finish          = 1'b1;
                w_result.status   = bpq_pkg::STATUS_OK;
                w_result.count    = r_count + 1'b1;
                w_result.is_empty = 1'b0;
                n_state           = S_IDLE;
            end
            S_FIND: begin
                // wait until the chain reflects the latest occupancy
                if (w_settled) begin
                    w_head_re = 1'b1;
                    w_tail_re = 1'b1;
                    w_tail_ra = w_min.key;
                    n_state   = S_RHEAD;
                end
            end
            S_RHEAD: begin
                w_ent_re  = 1'b1;
                w_link_re = 1'b1;
                w_link_ra = r_head_rd;
                n_state   = S_RWR;
            end
            S_RWR: begin
                if (r_head_rd == r_tail_rd) begin
                    w_cmd.clr = 1'b1;
                    w_cmd.key = r_rkey;
                end else begin
                    w_head_we = 1'b1;
                    w_head_wa = r_rkey;
                    w_head_wd = r_link_rd;
                end
                // push the released slot onto the free list
                w_link_we              = 1'b1;
                w_link_wa              = r_head_rd;
                w_link_wd              = r_free_head;
                w_finish               = 1'b1;
                w_result.removed_entry = r_ent_rd;
                w_result.removed_key   = r_rkey;
                w_result.status        = bpq_pkg::STATUS_OK;
                w_result.count         = r_count - 1'b1;
                w_result.is_empty      = (r_count == CW'(1));
                n_state                = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_ent_we) begin
            r_entry_mem[w_ent_wa] <= r_entry;
        end
        if (w_ent_re) begin
            r_ent_rd <= r_entry_mem[w_ent_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            r_link_mem[w_link_wa] <= w_link_wd;
        end
        if (w_link_re) begin
            r_link_rd <= r_link_mem[w_link_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            r_head_mem[w_head_wa] <= w_head_wd;
        end
        if (w_head_re) begin
            r_head_rd <= r_head_mem[w_head_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tail_we) begin
            r_tail_mem[w_tail_wa] <= w_tail_wd;
        end
        if (w_tail_re) begin
            r_tail_rd <= r_tail_mem[w_tail_ra];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_free_head     <= '0;
            r_free_nonempty <= 1'b0;
            r_fresh         <= '0;
            r_count         <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && i_in.kind == bpq_pkg::KIND_CLEAR) begin
                        r_free_head     <= '0;
                        r_free_nonempty <= 1'b0;
                        r_fresh         <= '0;
                        r_count         <= '0;
                    end
                end
                S_INS: begin
                    if (r_free_nonempty) begin
                        r_free_head     <= r_link_rd;
                        r_free_nonempty <= ((r_fresh - r_count) > CW'(1));
                    end else begin
                        r_fresh <= r_fresh + 1'b1;
                    end
                    r_count <= r_count + 1'b1;
                end
                S_RWR: begin
                    r_free_head     <= r_head_rd;
                    r_free_nonempty <= 1'b1;
                    r_count         <= r_count - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key     <= i_in.key;
            r_entry   <= i_in.entry;
            r_occ_hit <= w_occ_hit;
        end
        if (r_state == S_FIND && w_settled) begin
            r_rkey <= w_min.key;
        end
    end

    // result register with one-word hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (w_out_free) begin
                if (r_pend) begin
                    r_out       <= r_res;
                    r_out_valid <= 1'b1;
                    r_pend      <= 1'b0;
                end else if (w_finish) begin
                    r_out       <= w_result;
                    r_out_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b0;
                end
            end else if (w_finish) begin
                r_res  <= w_result;
                r_pend <= 1'b1;
            end
        end
    end

    assign i_in.ready          = w_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.removed_entry = r_out.removed_entry;
    assign o_out.removed_key   = r_out.removed_key;
    assign o_out.status        = r_out.status;
    assign o_out.count         = r_out.count;
    assign o_out.is_empty      = r_out.is_empty;

endmodule
